// ===== design/binary_thinning_subpass_unit_defines.svh =====
// Assertion macros for the binary thinning subpass unit.
// Included by RTL files that carry concurrent assertions; no other dependencies.
`ifndef BINARY_THINNING_SUBPASS_UNIT_DEFINES_SVH
`define BINARY_THINNING_SUBPASS_UNIT_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define BTSP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define BTSP_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== design/btsp_pkg.sv =====
// Shared types and constants for the binary thinning subpass unit.
// No dependencies; imported by every module of the block.
package btsp_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int CFG_W          = 11;
  localparam int CFG_IDX_W      = 2;
  localparam int OUT_DEPTH      = 4;
  localparam int OUT_PTR_W      = $clog2(OUT_DEPTH);
  localparam int OUT_LVL_W      = $clog2(OUT_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_SUBPASS      = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_FLUSH = 1'b1
  } kind_e;

  typedef enum logic {
    SUBPASS_FIRST  = 1'b0,
    SUBPASS_SECOND = 1'b1
  } subpass_e;

  typedef struct packed {
    logic pixel_out;
    logic deleted;
    logic frame_end;
  } res_t;

endpackage

// ===== design/btsp_judge.sv =====
// 3x3 window decision for one thinning subpass: neighbour count, ring transitions, products.
// Depends on btsp_pkg.
module btsp_judge (
  input  logic [8:0]          window_i,
  input  logic                interior_i,
  input  btsp_pkg::subpass_e  subpass_i,
  output logic                pixel_o,
  output logic                deleted_o
);
  import btsp_pkg::*;

  logic [7:0] ring;
  logic [7:0] ring_nx;
  logic [7:0] rise;
  logic [3:0] nb_cnt;
  logic [3:0] rise_cnt;
  logic       prod_ok;
  logic       centre;

  // ring order: north, north-east, east, south-east, south, south-west, west, north-west
  assign ring    = {window_i[0], window_i[1], window_i[2], window_i[5],
                    window_i[8], window_i[7], window_i[6], window_i[3]};
  assign ring_nx = {ring[0], ring[7:1]};
  assign rise    = ~ring & ring_nx;
  assign centre  = window_i[4];

  always_comb begin
    nb_cnt   = '0;
    rise_cnt = '0;
    for (int k = 0; k < 8; k++) begin
      nb_cnt   = nb_cnt + 4'(ring[k]);
      rise_cnt = rise_cnt + 4'(rise[k]);
    end
  end

  always_comb begin
    case (subpass_i)
      SUBPASS_FIRST:  prod_ok = !(ring[0] & ring[2] & ring[4]) && !(ring[2] & ring[4] & ring[6]);
      SUBPASS_SECOND: prod_ok = !(ring[0] & ring[2] & ring[6]) && !(ring[0] & ring[4] & ring[6]);
      default:        prod_ok = 1'b0;
    endcase
  end

  assign deleted_o = centre && interior_i && (nb_cnt >= 4'd2) && (nb_cnt <= 4'd6)
                     && (rise_cnt == 4'd1) && prod_ok;
  assign pixel_o   = centre && !deleted_o;

endmodule

// ===== design/btsp_out_fifo.sv =====
// Result queue between the window pipeline and the output channel.
// Depends on btsp_pkg for the result type and queue depth.
module btsp_out_fifo (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  input  btsp_pkg::res_t                    data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output btsp_pkg::res_t                    data_o,
  output logic [btsp_pkg::OUT_LVL_W-1:0]    level_o
);
  import btsp_pkg::*;

  res_t                 slot_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [OUT_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [OUT_LVL_W-1:0] cnt_q, cnt_d;
  logic                 pop;

  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign data_o      = slot_q[rd_ptr_q];
  assign level_o     = cnt_q;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + OUT_PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + OUT_PTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q + OUT_LVL_W'(push_i) - OUT_LVL_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== design/binary_thinning_subpass_unit.sv =====
// Top level of the binary thinning subpass unit: counters, line memory, window, result queue.
// Depends on btsp_pkg, btsp_judge, btsp_out_fifo and the assertion macro header.
`include "binary_thinning_subpass_unit_defines.svh"

// Binary pixels enter in raster order, one per clock unless stalled, and leave in raster
// order image_width+1 items behind the input. An accepted item has its line memory word
// read at the accepting edge and is judged in the following cycle, so its result is
// written into the result queue at the end of that cycle; a new item is taken every cycle
// unless stalled. The two line stores share one 2-bit-wide memory with a single read and
// a single write port; that port pair sets the one-item-per-clock rate. Up to four
// results wait in the output queue while the output is stalled, and the input stalls once
// the queue and the decision stage together hold four results. Flush items emit the last
// image_width+1 pixels of a frame. Writing a size register restarts the stream.
module binary_thinning_subpass_unit #(
  parameter int MAX_WIDTH  = btsp_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = btsp_pkg::MAX_HEIGHT_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             kind_i,
  input  logic                             pixel_in_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             pixel_out_o,
  output logic                             deleted_o,
  output logic                             frame_end_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [btsp_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [btsp_pkg::CFG_W-1:0]       cfg_data_i
);
  import btsp_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int LW  = $clog2(MAX_WIDTH + 2);
  localparam int SWW = (WW > CFG_W) ? WW : CFG_W;
  localparam int SHW = (HW > CFG_W) ? HW : CFG_W;

  // configuration
  logic [CFG_W-1:0] cfg_width_q, cfg_height_q;
  subpass_e         subpass_q;
  logic             cfg_we, restart;

  // sizes
  logic [SWW-1:0] wcfg;
  logic [SHW-1:0] hcfg;
  logic [WW-1:0]  w_eff;
  logic [HW-1:0]  h_eff;
  logic [CW-1:0]  w_last, w_m2;
  logic [RW-1:0]  h_last, h_m2;
  logic [LW-1:0]  lag_full;

  // position tracking
  logic [CW-1:0] in_col_q, in_col_d;
  logic [RW-1:0] in_row_q, in_row_d;
  logic [CW-1:0] out_col_q, out_col_d;
  logic [RW-1:0] out_row_q, out_row_d;
  logic [LW-1:0] lag_q, lag_d;
  logic [CW-1:0] ocol_eff;
  logic [RW-1:0] orow_eff;
  logic [LW-1:0] lag_eff;
  logic          acc, is_flush, in_zero, lag_nz, flush_go, out_rst, pix_emit, emit;
  logic          interior, fend, sel_near;
  logic [CW-1:0] rd_addr;

  // line memory: bit 1 far row, bit 0 near row
  logic [1:0]    line_mem [MAX_WIDTH];
  logic [1:0]    rd_q, rd_now, wr_data;

  // decision stage
  logic          b_valid_q, b_wr_q, b_flush_q, b_hit_q;
  logic          b_pix_q, b_interior_q, b_fend_q, b_sel_near_q;
  logic [CW-1:0] b_addr_q;
  logic [1:0]    b_byp_q;
  logic [8:0]    win_q, win_shift;
  logic          j_pixel, j_deleted;
  res_t          res_d, res_o;
  logic [OUT_LVL_W-1:0] fifo_level;

  // configuration port
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign restart     = cfg_we && ((cfg_index_i == CFG_IMAGE_WIDTH)
                                  || (cfg_index_i == CFG_IMAGE_HEIGHT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= CFG_W'(640);
      cfg_height_q <= CFG_W'(480);
      subpass_q    <= SUBPASS_FIRST;
    end else if (cfg_we) begin
      case (cfg_index_i)
        CFG_IMAGE_WIDTH:  cfg_width_q  <= cfg_data_i;
        CFG_IMAGE_HEIGHT: cfg_height_q <= cfg_data_i;
        CFG_SUBPASS:      subpass_q    <= subpass_e'(cfg_data_i[0]);
        default: ;
      endcase
    end
  end

  // clamp sizes
  always_comb begin
    wcfg = SWW'(cfg_width_q);
    hcfg = SHW'(cfg_height_q);
    if (wcfg < SWW'(3)) begin
      w_eff = WW'(3);
    end else if (wcfg > SWW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(wcfg);
    end
    if (hcfg < SHW'(3)) begin
      h_eff = HW'(3);
    end else if (hcfg > SHW'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(hcfg);
    end
    w_last   = CW'(w_eff - WW'(1));
    w_m2     = CW'(w_eff - WW'(2));
    h_last   = RW'(h_eff - HW'(1));
    h_m2     = RW'(h_eff - HW'(2));
    lag_full = LW'(w_eff) + LW'(1);
  end

  // input side control
  assign in_stall_o = ((OUT_LVL_W+1)'(fifo_level) + (OUT_LVL_W+1)'(b_valid_q))
                      >= (OUT_LVL_W+1)'(OUT_DEPTH);
  assign acc        = in_valid_i && !in_stall_o;
  assign is_flush   = (kind_i == KIND_FLUSH);
  assign in_zero    = (in_col_q == '0) && (in_row_q == '0);
  assign lag_nz     = (lag_q != '0);
  assign flush_go   = is_flush && in_zero && lag_nz;
  assign out_rst    = !is_flush && in_zero && lag_nz && (lag_q < lag_full);
  assign ocol_eff   = out_rst ? '0 : out_col_q;
  assign orow_eff   = out_rst ? '0 : out_row_q;
  assign lag_eff    = out_rst ? '0 : lag_q;
  assign pix_emit   = !is_flush && (lag_eff == lag_full);
  assign emit       = flush_go || pix_emit;
  assign interior   = (orow_eff != '0) && (orow_eff <= h_m2)
                      && (ocol_eff != '0) && (ocol_eff <= w_m2);
  assign fend       = (orow_eff == h_last) && (ocol_eff == w_last);
  assign sel_near   = (out_row_q == h_last);
  assign rd_addr    = is_flush ? out_col_q : in_col_q;

  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    lag_d     = lag_q;
    if (restart) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
      lag_d     = '0;
    end else if (acc) begin
      if (!is_flush) begin
        if (in_col_q == w_last) begin
          in_col_d = '0;
          in_row_d = (in_row_q == h_last) ? '0 : in_row_q + RW'(1);
        end else begin
          in_col_d = in_col_q + CW'(1);
        end
      end
      out_col_d = ocol_eff;
      out_row_d = orow_eff;
      if (emit) begin
        if (ocol_eff == w_last) begin
          out_col_d = '0;
          out_row_d = (orow_eff == h_last) ? '0 : orow_eff + RW'(1);
        end else begin
          out_col_d = ocol_eff + CW'(1);
        end
      end
      if (flush_go) begin
        lag_d = lag_q - LW'(1);
      end else if (!is_flush) begin
        lag_d = pix_emit ? lag_eff : lag_eff + LW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      lag_q     <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      lag_q     <= lag_d;
    end
  end

  // line memory: shift near into far, write new pixel into near
  assign rd_now  = b_hit_q ? b_byp_q : rd_q;
  assign wr_data = {rd_now[0], b_pix_q};

  always_ff @(posedge clk_i) begin
    if (b_wr_q) begin
      line_mem[b_addr_q] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      rd_q <= line_mem[rd_addr];
    end
  end

  // decision stage registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      b_wr_q    <= 1'b0;
      b_flush_q <= 1'b0;
      b_hit_q   <= 1'b0;
    end else begin
      b_valid_q <= acc && emit;
      b_wr_q    <= acc && !is_flush;
      b_flush_q <= is_flush;
      b_hit_q   <= acc && b_wr_q && (b_addr_q == rd_addr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      b_pix_q      <= pixel_in_i;
      b_addr_q     <= rd_addr;
      b_interior_q <= interior;
      b_fend_q     <= fend;
      b_sel_near_q <= sel_near;
      b_byp_q      <= wr_data;
    end
  end

  // window: columns oldest to newest, each top, middle, bottom
  assign win_shift = {b_pix_q, rd_now[0], rd_now[1], win_q[8:3]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (restart) begin
      win_q <= '0;
    end else if (b_wr_q) begin
      win_q <= win_shift;
    end
  end

  btsp_judge u_judge (
    .window_i   (win_shift),
    .interior_i (b_interior_q),
    .subpass_i  (subpass_q),
    .pixel_o    (j_pixel),
    .deleted_o  (j_deleted)
  );

  always_comb begin
    res_d.frame_end = b_fend_q;
    if (b_flush_q) begin
      res_d.pixel_out = b_sel_near_q ? rd_now[0] : rd_now[1];
      res_d.deleted   = 1'b0;
    end else begin
      res_d.pixel_out = j_pixel;
      res_d.deleted   = j_deleted;
    end
  end

  btsp_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (b_valid_q),
    .data_i      (res_d),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .data_o      (res_o),
    .level_o     (fifo_level)
  );

  assign pixel_out_o = res_o.pixel_out;
  assign deleted_o   = res_o.deleted;
  assign frame_end_o = res_o.frame_end;

  `BTSP_ASSERT_NEVER(a_lag_bound, clk_i, rst_ni, lag_q > lag_full, "pixel lag beyond one row")
  `BTSP_ASSERT_NEVER(a_col_bound, clk_i, rst_ni, in_col_q > w_last, "input column out of row")
  `BTSP_ASSERT(a_push_room, clk_i, rst_ni, b_valid_q |-> (fifo_level < OUT_LVL_W'(OUT_DEPTH)),
    "result pushed into full queue")
  `BTSP_ASSERT(a_del_clear, clk_i, rst_ni, (out_valid_o && deleted_o) |-> !pixel_out_o,
    "deleted pixel still foreground")

endmodule

// ===== dv/thinning_result_checker.sv =====
`timescale 1ns / 1ps
// Checker for the binary thinning subpass unit: tracks register writes, predicts each
// thinned pixel from the accepted input stream and compares every result transaction.
// Depends on btsp_pkg only.
module thinning_result_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic                           kind_i,
  input  logic                           pixel_in_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic                           pixel_out_i,
  input  logic                           deleted_i,
  input  logic                           frame_end_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [btsp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [btsp_pkg::CFG_W-1:0]     cfg_data_i,
  output int                             fail_count_o,
  output int                             pending_o
);
  import btsp_pkg::*;

  localparam int MAX_W = MAX_WIDTH_DEF;
  localparam int MAX_H = MAX_HEIGHT_DEF;
  localparam logic [CFG_W-1:0] WIDTH_AT_RESET  = 11'd640;
  localparam logic [CFG_W-1:0] HEIGHT_AT_RESET = 11'd480;

  logic             row_above  [MAX_W];
  logic             row_above2 [MAX_W];
  logic [8:0]       nbhd;
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  subpass_e         pass_sel;
  int unsigned      wr_col, wr_row, rd_col, rd_row;
  res_t             thinned_q[$];
  int               mismatches = 0;

  assign fail_count_o = mismatches;

  function automatic int unsigned clamp_dim(logic [CFG_W-1:0] raw, int unsigned hi);
    if (raw < 3) return 3;
    if (raw > hi) return hi;
    return 32'(raw);
  endfunction

  function automatic void restart_stream();
    nbhd   = '0;
    wr_col = 0;
    wr_row = 0;
    rd_col = 0;
    rd_row = 0;
  endfunction

  // window columns are 3-bit groups (old, mid, new), each top/middle/bottom from bit 0
  function automatic logic thinned_centre(int unsigned w, int unsigned h, output logic del);
    logic [7:0]  ring;
    int unsigned fg;
    int unsigned rises;
    logic        cond;
    del = 1'b0;
    if (!nbhd[4] || rd_row < 1 || rd_row > h - 2 || rd_col < 1 || rd_col > w - 2)
      return nbhd[4];
    // ring[0] north, then clockwise to ring[7] north-west
    ring  = {nbhd[0], nbhd[1], nbhd[2], nbhd[5], nbhd[8], nbhd[7], nbhd[6], nbhd[3]};
    fg    = $countones(ring);
    rises = 0;
    for (int k = 0; k < 8; k++) begin
      if (!ring[k] && ring[(k + 1) % 8]) rises++;
    end
    if (pass_sel == SUBPASS_FIRST) begin
      cond = !(ring[0] & ring[2] & ring[4]) && !(ring[2] & ring[4] & ring[6]);
    end else begin
      cond = !(ring[0] & ring[2] & ring[6]) && !(ring[0] & ring[4] & ring[6]);
    end
    if (fg >= 2 && fg <= 6 && rises == 1 && cond) begin
      del = 1'b1;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void queue_result(logic pix, logic del, int unsigned w, int unsigned h);
    res_t r;
    r.pixel_out = pix;
    r.deleted   = del;
    r.frame_end = (rd_row == h - 1) && (rd_col == w - 1);
    thinned_q   = {thinned_q, r};
    rd_col++;
    if (rd_col >= w) begin
      rd_col = 0;
      rd_row++;
      if (rd_row >= h) rd_row = 0;
    end
  endfunction

  task automatic predict_item(kind_e k, logic px);
    int unsigned w, h, in_pos, out_pos, lag;
    logic        far_bit, near_bit, pix, del;
    w       = clamp_dim(width_reg, MAX_W);
    h       = clamp_dim(height_reg, MAX_H);
    in_pos  = wr_row * w + wr_col;
    out_pos = rd_row * w + rd_col;
    lag     = (in_pos >= out_pos) ? in_pos - out_pos : in_pos + w * h - out_pos;
    if (k == KIND_FLUSH) begin
      // drain only from a frame boundary with a tail still held
      if (in_pos == 0 && lag != 0) begin
        pix = (rd_row == h - 1) ? row_above[rd_col] : row_above2[rd_col];
        queue_result(pix, 1'b0, w, h);
      end
      return;
    end
    // drop an interrupted tail
    if (in_pos == 0 && lag > 0 && lag < w + 1) begin
      rd_row = 0;
      rd_col = 0;
      lag    = 0;
    end
    far_bit            = row_above2[wr_col];
    near_bit           = row_above[wr_col];
    row_above2[wr_col] = near_bit;
    row_above[wr_col]  = px;
    nbhd               = {px, near_bit, far_bit, nbhd[8:3]};
    wr_col++;
    if (wr_col >= w) begin
      wr_col = 0;
      wr_row++;
      if (wr_row >= h) wr_row = 0;
    end
    if (lag == w + 1) begin
      pix = thinned_centre(w, h, del);
      queue_result(pix, del, w, h);
    end
  endtask

  always @(posedge clk_i) begin : watch
    res_t exp_r;
    if (!rst_ni) begin
      width_reg  = WIDTH_AT_RESET;
      height_reg = HEIGHT_AT_RESET;
      pass_sel   = SUBPASS_FIRST;
      for (int i = 0; i < MAX_W; i++) begin
        row_above[i]  = 1'b0;
        row_above2[i] = 1'b0;
      end
      restart_stream();
      thinned_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_IMAGE_WIDTH: begin
            width_reg = cfg_data_i;
            restart_stream();
          end
          CFG_IMAGE_HEIGHT: begin
            height_reg = cfg_data_i;
            restart_stream();
          end
          CFG_SUBPASS: begin
            pass_sel = subpass_e'(cfg_data_i[0]);
          end
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (thinned_q.size() == 0) begin
          $error("result transaction with none expected: pixel_out %0b deleted %0b frame_end %0b",
                 pixel_out_i, deleted_i, frame_end_i);
          mismatches++;
        end else begin
          exp_r = thinned_q.pop_front();
          if (pixel_out_i !== exp_r.pixel_out) begin
            $error("pixel_out: expected %0b, actual %0b", exp_r.pixel_out, pixel_out_i);
            mismatches++;
          end
          if (deleted_i !== exp_r.deleted) begin
            $error("deleted: expected %0b, actual %0b", exp_r.deleted, deleted_i);
            mismatches++;
          end
          if (frame_end_i !== exp_r.frame_end) begin
            $error("frame_end: expected %0b, actual %0b", exp_r.frame_end, frame_end_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) predict_item(kind_e'(kind_i), pixel_in_i);
    end
    pending_o <= thinned_q.size();
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the thinning subpass testbench: clock, reset, pixel and register stimulus,
// random back-pressure and the verdict. Depends on btsp_pkg, the unit and the checker.
module tb_top;
  import btsp_pkg::*;

  localparam int ITEM_TARGET  = 1975;
  localparam int CALM_TAIL    = 250;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 80;
  localparam int WIDE_AT      = 700;
  localparam int PIPE_SLACK   = 8;
  localparam int END_SLACK    = 20;
  localparam int QUIET_LIMIT  = 2000;
  localparam logic [8:0] CORNER_FRAME = 9'b110_110_000;

  logic             clk           = 1'b0;
  logic             rst_n         = 1'b0;
  logic             in_valid      = 1'b0;
  logic             in_stall;
  kind_e            in_kind       = KIND_PIXEL;
  logic             in_pixel      = 1'b0;
  logic             out_valid;
  logic             out_stall     = 1'b0;
  logic             res_pixel;
  logic             res_deleted;
  logic             res_frame_end;
  logic             cfg_valid     = 1'b0;
  logic             cfg_ready;
  cfg_idx_e         cfg_index     = CFG_IMAGE_WIDTH;
  logic [CFG_W-1:0] cfg_data      = '0;
  int               fails;
  int               pending;

  int               items_offered = 0;
  bit               calm          = 1'b0;
  bit               long_hold_req = 1'b0;
  int unsigned      cur_w         = 640;
  int unsigned      cur_h         = 480;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  binary_thinning_subpass_unit uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .kind_i      (in_kind),
    .pixel_in_i  (in_pixel),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .pixel_out_o (res_pixel),
    .deleted_o   (res_deleted),
    .frame_end_o (res_frame_end),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  thinning_result_checker thinning_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .kind_i       (in_kind),
    .pixel_in_i   (in_pixel),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .pixel_out_i  (res_pixel),
    .deleted_i    (res_deleted),
    .frame_end_i  (res_frame_end),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fails),
    .pending_o    (pending)
  );

  function automatic int unsigned clamped(logic [CFG_W-1:0] raw, int unsigned hi);
    if (raw < 3) return 3;
    if (raw > hi) return hi;
    return 32'(raw);
  endfunction

  task automatic offer(kind_e k, logic px);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind  <= k;
    in_pixel <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_offered++;
    if (items_offered == HOLD_AT) long_hold_req = 1'b1;
    if (items_offered >= ITEM_TARGET - CALM_TAIL) calm = 1'b1;
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // wait for the unit to go quiet, then write the registers
  task automatic reconfigure(logic [CFG_W-1:0] raw_w, logic [CFG_W-1:0] raw_h,
                             logic [CFG_W-1:0] pass_word, bit sizes);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (PIPE_SLACK) @(posedge clk);
    if (sizes) begin
      write_reg(CFG_IMAGE_WIDTH, raw_w);
      write_reg(CFG_IMAGE_HEIGHT, raw_h);
      cur_w = clamped(raw_w, MAX_WIDTH_DEF);
      cur_h = clamped(raw_h, MAX_HEIGHT_DEF);
    end
    write_reg(CFG_SUBPASS, pass_word);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_frame(int unsigned w, int unsigned h);
    int unsigned shape, dens, r0, r1, c0, c1;
    logic        px;
    shape = $urandom_range(0, 2);
    dens  = $urandom_range(30, 85);
    r0    = $urandom_range(0, h - 1);
    r1    = $urandom_range(r0, h - 1);
    c0    = $urandom_range(0, w - 1);
    c1    = $urandom_range(c0, w - 1);
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        if ((r != 0 || c != 0) && $urandom_range(0, 49) == 0) begin
          offer(KIND_FLUSH, 1'($urandom_range(0, 1)));
        end
        if (shape == 0) begin
          px = ($urandom_range(0, 99) < dens);
        end else begin
          px = (r >= r0 && r <= r1 && c >= c0 && c <= c1) ^ ($urandom_range(0, 29) == 0);
        end
        offer(KIND_PIXEL, px);
      end
    end
  endtask

  function automatic logic [CFG_W-1:0] random_pass_word();
    return {10'($urandom_range(0, 1023)), 1'($urandom_range(0, 1))};
  endfunction

  initial begin : receiver
    @(posedge rst_n);
    forever begin
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin : stimulus
    int unsigned nframes;
    int unsigned pick;
    bit          wide_done;
    wide_done = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    reconfigure(11'd0, 11'd2, {10'd0, SUBPASS_FIRST}, 1'b1);
    offer(KIND_FLUSH, 1'b1);
    for (int i = 8; i >= 0; i--) offer(KIND_PIXEL, CORNER_FRAME[i]);
    for (int i = 0; i < 9; i++) begin
      if (i == 4) offer(KIND_FLUSH, 1'b0);
      offer(KIND_PIXEL, 1'b1);
    end
    repeat (4) offer(KIND_FLUSH, 1'($urandom_range(0, 1)));
    offer(KIND_FLUSH, 1'b0);

    while (items_offered < ITEM_TARGET) begin
      if (!wide_done && items_offered >= WIDE_AT) begin
        wide_done = 1'b1;
        reconfigure(11'd1024, 11'd3, random_pass_word(), 1'b1);
        repeat (cur_w + 1 + $urandom_range(4, 12)) offer(KIND_PIXEL, 1'($urandom_range(0, 1)));
        reconfigure(11'd2047, 11'd2047, random_pass_word(), 1'b1);
        repeat (6) offer(KIND_PIXEL, 1'($urandom_range(0, 1)));
        reconfigure(11'd3, 11'd1024, random_pass_word(), 1'b1);
        repeat (20) offer(KIND_PIXEL, 1'($urandom_range(0, 1)));
      end
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        reconfigure(CFG_W'($urandom_range(0, 2)), CFG_W'($urandom_range(0, 6)),
                    random_pass_word(), 1'b1);
      end else if (pick < 3 && cur_w * cur_h <= 80) begin
        reconfigure(CFG_W'(cur_w), CFG_W'(cur_h), random_pass_word(), 1'b0);
      end else begin
        reconfigure(CFG_W'($urandom_range(3, 10)), CFG_W'($urandom_range(3, 8)),
                    random_pass_word(), 1'b1);
      end
      nframes = $urandom_range(1, 3);
      for (int f = 0; f < nframes; f++) begin
        send_frame(cur_w, cur_h);
        case ($urandom_range(0, 3))
          0: ;
          1: repeat ($urandom_range(1, cur_w)) offer(KIND_FLUSH, 1'($urandom_range(0, 1)));
          default: begin
            repeat (cur_w + 1 + $urandom_range(0, 1)) offer(KIND_FLUSH, 1'($urandom_range(0, 1)));
          end
        endcase
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (END_SLACK) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
